// File: hw/rtl/mmdc_pkg.sv
// ---------------------------------------------------------------------------
// mmdc_pkg
// Shared types and constants for the MESI multicore direct-mapped cache.
// ---------------------------------------------------------------------------
package mmdc_pkg;

  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned ADDR_SPAN = 2 ** ADDR_W;

  typedef enum logic [1:0] {
    MESI_INVALID   = 2'd0,
    MESI_SHARED    = 2'd1,
    MESI_EXCLUSIVE = 2'd2,
    MESI_MODIFIED  = 2'd3
  } mesi_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } ctrl_state_t;

  typedef struct packed {
    logic              core;
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic              served_core;
    logic              was_write;
    logic [ADDR_W-1:0] line_address;
    logic [DATA_W-1:0] line_data;
    mesi_t             line_state;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic look;
    logic update;
  } cmd_t;

endpackage

// File: hw/rtl/mesi_multicore_direct_mapped_cache.sv
// ---------------------------------------------------------------------------
// mesi_multicore_direct_mapped_cache
// MESI-coherent set of per-core direct-mapped one-byte-line caches.
// ---------------------------------------------------------------------------
// Usage:
//   Drive in_req and raise start; the access transfers at the rising edge
//   where start is high and busy is low. Each access names a core, read or
//   write, a byte address and write data.
//   Every access yields exactly one result on out_res, shown for a single
//   cycle with out_strobe high. The receiver cannot stall the result, so
//   nothing holds it; sample it in that cycle.
// Sequence:
//   An access runs through the accept cycle, a lookup cycle (main-memory
//   read of the request address and write-back of a displaced Shared or
//   Modified line on the single memory port) and an update cycle that
//   writes the requester's line and the state of other cores' copies in
//   the set. The result strobe follows in the next cycle, which also
//   accepts the next access; a new access is not taken before then.
// Reset:
//   rst_n low clears all lines to Invalid with zero tag and data, and clears
//   the per-word valid bits of main memory so every word reads as zero.
//   No clearing pass is needed: the block accepts right after reset.
// ---------------------------------------------------------------------------
module mesi_multicore_direct_mapped_cache
  import mmdc_pkg::*;
#(
  parameter int unsigned CORE_CNT     = 2,
  parameter int unsigned CACHE_LINES  = 2,
  parameter int unsigned MEMORY_WORDS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_strobe,
  output res_t out_res
);

  // Command bundle from the sequencer to the datapath
  cmd_t cmd;

  // Sequence each access: accept, look up and write back, update
  mmdc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the line arrays, main memory and the result register
  mmdc_dp #(
    .CORE_CNT     (CORE_CNT),
    .CACHE_LINES  (CACHE_LINES),
    .MEMORY_WORDS (MEMORY_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

// File: hw/rtl/mmdc_ctrl.sv
// ---------------------------------------------------------------------------
// mmdc_ctrl
// Access sequencer: accept, look up and write back, then update the lines.
// ---------------------------------------------------------------------------
module mmdc_ctrl
  import mmdc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    busy        = 1'b1;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/mmdc_dp.sv
// ---------------------------------------------------------------------------
// mmdc_dp
// Request registers, per-core line arrays, shared main memory, result register.
// ---------------------------------------------------------------------------
module mmdc_dp
  import mmdc_pkg::*;
#(
  parameter int unsigned CORE_CNT     = 2,
  parameter int unsigned CACHE_LINES  = 2,
  parameter int unsigned MEMORY_WORDS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  req_t in_req,
  output logic out_strobe,
  output res_t out_res
);

  localparam int unsigned CORE_W    = $clog2(CORE_CNT);
  localparam int unsigned SET_W     = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
  localparam int unsigned MEM_DEPTH = (MEMORY_WORDS > ADDR_SPAN) ? ADDR_SPAN : MEMORY_WORDS;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  // Constant address reduction and set tables
  logic [ADDR_W-1:0] addr_tbl [ADDR_SPAN];
  logic [SET_W-1:0]  set_tbl  [ADDR_SPAN];

  for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_tbl
    localparam int unsigned RA = g % MEMORY_WORDS;
    localparam int unsigned RS = RA % CACHE_LINES;
    assign addr_tbl[g] = ADDR_W'(RA);
    assign set_tbl[g]  = SET_W'(RS);
  end

  // Request registers
  logic [CORE_W-1:0] core_r;
  logic              wr_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SET_W-1:0]  set_r;
  logic [DATA_W-1:0] wdata_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      core_r  <= CORE_W'(in_req.core);
      wr_r    <= in_req.operation;
      addr_r  <= addr_tbl[in_req.address];
      set_r   <= set_tbl[in_req.address];
      wdata_r <= in_req.write_data;
    end
  end

  // Line arrays, one row of sets per core
  logic [ADDR_W-1:0] tag_r    [CORE_CNT][CACHE_LINES];
  logic [DATA_W-1:0] val_r    [CORE_CNT][CACHE_LINES];
  mesi_t             mesi_r   [CORE_CNT][CACHE_LINES];
  logic [ADDR_W-1:0] tag_nxt  [CORE_CNT][CACHE_LINES];
  logic [DATA_W-1:0] val_nxt  [CORE_CNT][CACHE_LINES];
  mesi_t             mesi_nxt [CORE_CNT][CACHE_LINES];

  // Requester's line and the other cores' copies in the same set
  logic [ADDR_W-1:0] me_tag;
  logic [DATA_W-1:0] me_val;
  mesi_t             me_mesi;
  logic              me_hit;
  logic              wb_req;
  logic [CORE_CNT-1:0] copy_vec;
  logic [CORE_CNT-1:0] tag_eq_vec;
  logic [DATA_W-1:0] copy_val;

  assign me_tag  = tag_r[core_r][set_r];
  assign me_val  = val_r[core_r][set_r];
  assign me_mesi = mesi_r[core_r][set_r];
  assign me_hit  = (me_tag == addr_r) && (me_mesi != MESI_INVALID);
  assign wb_req  = (me_tag != addr_r) &&
                   ((me_mesi == MESI_MODIFIED) || (me_mesi == MESI_SHARED));

  always_comb begin
    copy_vec   = '0;
    tag_eq_vec = '0;
    copy_val   = '0;
    for (int i = 0; i < CORE_CNT; i++) begin
      if ((CORE_W'(i) != core_r) && (tag_r[i][set_r] == addr_r)) begin
        tag_eq_vec[i] = 1'b1;
        if (mesi_r[i][set_r] != MESI_INVALID) begin
          copy_vec[i] = 1'b1;
          // highest-numbered copy supplies the data
          copy_val    = val_r[i][set_r];
        end
      end
    end
  end

  // Main memory with per-word valid bits; an unwritten word reads as zero
  logic [DATA_W-1:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld_r;
  logic [DATA_W-1:0]    rd_data_r;
  logic                 rd_vld_r;
  logic [MEM_AW-1:0]    rd_idx;
  logic [MEM_AW-1:0]    wb_idx;
  logic [DATA_W-1:0]    mem_byte;

  assign rd_idx   = addr_r[MEM_AW-1:0];
  assign wb_idx   = me_tag[MEM_AW-1:0];
  assign mem_byte = rd_vld_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      rd_data_r <= mem[rd_idx];
      rd_vld_r  <= mem_vld_r[rd_idx];
      if (wb_req) begin
        mem[wb_idx] <= me_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
    end else if (cmd.look && wb_req) begin
      mem_vld_r[wb_idx] <= 1'b1;
    end
  end

  // Final state of the requester's line
  logic [ADDR_W-1:0] new_tag;
  logic [DATA_W-1:0] new_val;
  mesi_t             new_mesi;

  always_comb begin
    priority if (wr_r) begin
      new_tag  = addr_r;
      new_val  = wdata_r;
      new_mesi = MESI_MODIFIED;
    end else if (!me_hit) begin
      new_tag = addr_r;
      if (|copy_vec) begin
        new_val  = copy_val;
        new_mesi = MESI_SHARED;
      end else begin
        new_val  = mem_byte;
        new_mesi = MESI_EXCLUSIVE;
      end
    end else begin
      // read hit: hold the line
      new_tag  = me_tag;
      new_val  = me_val;
      new_mesi = me_mesi;
    end
  end

  always_comb begin
    tag_nxt  = tag_r;
    val_nxt  = val_r;
    mesi_nxt = mesi_r;
    if (cmd.update) begin
      for (int i = 0; i < CORE_CNT; i++) begin
        if (CORE_W'(i) == core_r) begin
          tag_nxt[i][set_r]  = new_tag;
          val_nxt[i][set_r]  = new_val;
          mesi_nxt[i][set_r] = new_mesi;
        end else if (wr_r && tag_eq_vec[i]) begin
          mesi_nxt[i][set_r] = MESI_INVALID;
        end else if (!wr_r && !me_hit && copy_vec[i]) begin
          mesi_nxt[i][set_r] = MESI_SHARED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORE_CNT; i++) begin
        for (int s = 0; s < CACHE_LINES; s++) begin
          tag_r[i][s]  <= '0;
          val_r[i][s]  <= '0;
          mesi_r[i][s] <= MESI_INVALID;
        end
      end
    end else begin
      tag_r  <= tag_nxt;
      val_r  <= val_nxt;
      mesi_r <= mesi_nxt;
    end
  end

  // Result register
  logic out_strobe_r;
  res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_r.served_core  <= core_r[0];
      res_r.was_write    <= wr_r;
      res_r.line_address <= new_tag;
      res_r.line_data    <= new_val;
      res_r.line_state   <= new_mesi;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = res_r;

endmodule

// File: dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the MESI multicore direct-mapped cache. A directed
// table of accesses covers the protocol corners: cold misses, read hits,
// write invalidation, cache-to-cache supply and victim write-back. Bursts of
// random accesses follow, mostly over a small pool of hot addresses so that
// lines collide and are shared between cores. A bench-side model of every
// core's lines and of main memory predicts each result the table does not pin.
// ---------------------------------------------------------------------------
module tb;
  import mmdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CORE_CNT     = 2;
  localparam int unsigned CACHE_LINES  = 2;
  localparam int unsigned MEMORY_WORDS = 32;
  localparam int unsigned NUM_LINES    = CORE_CNT * CACHE_LINES;

  // Access kinds carried in req_t.operation
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;  // cycles with no transfer
  localparam int unsigned RANDOM_PHASES  = 7;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned HOT_ADDRS      = 4;
  localparam int unsigned DIR_ROWS       = 22;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_strobe;
  res_t out_res;

  mesi_multicore_direct_mapped_cache #(
    .CORE_CNT    (CORE_CNT),
    .CACHE_LINES (CACHE_LINES),
    .MEMORY_WORDS(MEMORY_WORDS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

  // 2 ns period: one delay high, one delay low.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // -------------------------------------------------------------------------
  // Shadow copy of the cache and memory contents. Slot index is
  // core * CACHE_LINES + set, the same packing the block uses per core.
  // -------------------------------------------------------------------------
  logic [ADDR_W-1:0] shadow_tag   [NUM_LINES];
  logic [DATA_W-1:0] shadow_value [NUM_LINES];
  mesi_t             shadow_mesi  [NUM_LINES];
  logic [DATA_W-1:0] shadow_mem   [MEMORY_WORDS];

  // Results still owed by the block, oldest first.
  res_t pending_results [$];
  res_t oldest_result;

  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned reads_sent;
  int unsigned writes_sent;
  int unsigned state_seen [4];
  logic [ADDR_W-1:0] hot_addr [HOT_ADDRS];

  // Directed table. Rows with pinned set carry an expectation worked out by
  // hand from the reset state; the rest fall back to the shadow model.
  typedef struct packed {
    req_t req;
    logic pinned;
    res_t res;
  } directed_row_t;

  directed_row_t directed_tbl [DIR_ROWS] = '{
    // cold read of address 0: tag matches but line is invalid, load exclusive
    '{'{1'b0, OP_READ,  5'd0,  8'd0},   1'b1, '{1'b0, OP_READ,  5'd0,  8'd0,   MESI_EXCLUSIVE}},
    // read hit leaves the line alone
    '{'{1'b0, OP_READ,  5'd0,  8'd0},   1'b1, '{1'b0, OP_READ,  5'd0,  8'd0,   MESI_EXCLUSIVE}},
    // write at the top address with all-ones data
    '{'{1'b1, OP_WRITE, 5'd31, 8'd255}, 1'b1, '{1'b1, OP_WRITE, 5'd31, 8'd255, MESI_MODIFIED}},
    // modified copy in core 1 supplies core 0, both go shared
    '{'{1'b0, OP_READ,  5'd31, 8'd0},   1'b1, '{1'b0, OP_READ,  5'd31, 8'd255, MESI_SHARED}},
    '{'{1'b1, OP_READ,  5'd31, 8'd0},   1'b1, '{1'b1, OP_READ,  5'd31, 8'd255, MESI_SHARED}},
    // write hit on an exclusive line
    '{'{1'b0, OP_WRITE, 5'd0,  8'd0},   1'b1, '{1'b0, OP_WRITE, 5'd0,  8'd0,   MESI_MODIFIED}},
    '{'{1'b1, OP_READ,  5'd0,  8'd0},   1'b1, '{1'b1, OP_READ,  5'd0,  8'd0,   MESI_SHARED}},
    // shared victim written back, then a cold load
    '{'{1'b0, OP_READ,  5'd2,  8'd0},   1'b1, '{1'b0, OP_READ,  5'd2,  8'd0,   MESI_EXCLUSIVE}},
    // exclusive victim dropped, write installs modified
    '{'{1'b0, OP_WRITE, 5'd4,  8'd170}, 1'b1, '{1'b0, OP_WRITE, 5'd4,  8'd170, MESI_MODIFIED}},
    // modified victim written back
    '{'{1'b0, OP_READ,  5'd6,  8'd0},   1'b1, '{1'b0, OP_READ,  5'd6,  8'd0,   MESI_EXCLUSIVE}},
    // the written-back byte comes back from memory
    '{'{1'b1, OP_READ,  5'd4,  8'd0},   1'b1, '{1'b1, OP_READ,  5'd4,  8'd170, MESI_EXCLUSIVE}},
    '{'{1'b0, OP_READ,  5'd8,  8'd0},   1'b0, '0},
    '{'{1'b1, OP_WRITE, 5'd4,  8'd85},  1'b0, '0},
    // write invalidates the other core's copy of the same address
    '{'{1'b0, OP_WRITE, 5'd4,  8'd1},   1'b0, '0},
    '{'{1'b1, OP_READ,  5'd4,  8'd0},   1'b0, '0},
    '{'{1'b0, OP_WRITE, 5'd31, 8'd0},   1'b0, '0},
    // invalid line whose tag still matches: miss served by the other core
    '{'{1'b1, OP_READ,  5'd31, 8'd0},   1'b0, '0},
    '{'{1'b1, OP_WRITE, 5'd1,  8'd255}, 1'b0, '0},
    '{'{1'b0, OP_READ,  5'd31, 8'd0},   1'b0, '0},
    // write data on a read is ignored
    '{'{1'b0, OP_READ,  5'd1,  8'd255}, 1'b0, '0},
    '{'{1'b1, OP_READ,  5'd30, 8'd0},   1'b0, '0},
    '{'{1'b0, OP_WRITE, 5'd30, 8'd128}, 1'b0, '0}
  };

  // -------------------------------------------------------------------------
  // Advance the shadow model by one access and return the line it leaves.
  // -------------------------------------------------------------------------
  function automatic res_t apply_access(input req_t acc);
    int unsigned core_id;
    int unsigned set_id;
    int unsigned own;
    int unsigned peer;
    logic [ADDR_W-1:0] addr;
    logic found;
    res_t line;
    core_id = acc.core % CORE_CNT;
    addr    = ADDR_W'(acc.address % MEMORY_WORDS);
    set_id  = addr % CACHE_LINES;
    own     = core_id * CACHE_LINES + set_id;
    found   = 1'b0;

    // Displaced dirty or shared line goes back to memory first.
    if (shadow_tag[own] != addr &&
        (shadow_mesi[own] == MESI_MODIFIED || shadow_mesi[own] == MESI_SHARED)) begin
      shadow_mem[shadow_tag[own] % MEMORY_WORDS] = shadow_value[own];
      shadow_value[own] = shadow_mem[addr];
    end

    if (acc.operation == OP_WRITE) begin
      shadow_tag[own]   = addr;
      shadow_value[own] = acc.write_data;
      shadow_mesi[own]  = MESI_MODIFIED;
      // Drop matching copies elsewhere; the tag alone decides.
      for (int unsigned k = 0; k < CORE_CNT; k++) begin
        peer = k * CACHE_LINES + set_id;
        if (k != core_id && shadow_tag[peer] == addr) shadow_mesi[peer] = MESI_INVALID;
      end
    end else if (shadow_tag[own] != addr || shadow_mesi[own] == MESI_INVALID) begin
      // Scan peers in ascending order; the last valid copy supplies the data.
      for (int unsigned k = 0; k < CORE_CNT; k++) begin
        peer = k * CACHE_LINES + set_id;
        if (k != core_id && shadow_tag[peer] == addr && shadow_mesi[peer] != MESI_INVALID) begin
          shadow_tag[own]   = shadow_tag[peer];
          shadow_value[own] = shadow_value[peer];
          shadow_mesi[peer] = MESI_SHARED;
          shadow_mesi[own]  = MESI_SHARED;
          found = 1'b1;
        end
      end
      if (!found) begin
        shadow_value[own] = shadow_mem[addr];
        shadow_mesi[own]  = MESI_EXCLUSIVE;
        shadow_tag[own]   = addr;
      end
    end

    line.served_core  = core_id[0];
    line.was_write    = acc.operation;
    line.line_address = shadow_tag[own];
    line.line_data    = shadow_value[own];
    line.line_state   = shadow_mesi[own];
    return line;
  endfunction

  // -------------------------------------------------------------------------
  // Sender side
  // -------------------------------------------------------------------------

  // Present one access at the falling edge and hold it until it transfers.
  // Start stays high when the caller sends again right away.
  task automatic send_access(input req_t acc, input logic pinned, input res_t pinned_res);
    res_t predicted;
    @(negedge clk);
    in_req <= acc;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = apply_access(acc);
    pending_results.push_back(pinned ? pinned_res : predicted);
    if (acc.operation == OP_WRITE) writes_sent++;
    else reads_sent++;
  endtask

  // Drop start for a number of cycles.
  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Drop start and hold off until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random bursts. Most accesses hit a small pool of hot addresses so that
  // the cores keep colliding on the same lines; the rest roam all of memory.
  task automatic run_random(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    req_t acc;
    left  = count;
    burst = 0;
    for (int unsigned k = 0; k < HOT_ADDRS; k++) hot_addr[k] = ADDR_W'($urandom_range(0, 31));
    while (left != 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
      acc.core       = 1'($urandom_range(0, 1));
      acc.operation  = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      acc.write_data = DATA_W'($urandom_range(0, 255));
      if ($urandom_range(0, 4) != 0) acc.address = hot_addr[$urandom_range(0, HOT_ADDRS - 1)];
      else acc.address = ADDR_W'($urandom_range(0, 31));
      send_access(acc, 1'b0, '0);
      burst--;
      left--;
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: compare each strobed result with the oldest expectation.
  // -------------------------------------------------------------------------
  task automatic report_field(input string field, input int exp_v, input int act_v);
    $error("%s: expected %0d, got %0d", field, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      // Watchdog: any transfer in either direction restarts the count.
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d idle cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
      end

      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          $error("result with no access outstanding: %p", out_res);
          mismatches++;
        end else begin
          oldest_result = pending_results.pop_front();
          state_seen[out_res.line_state]++;
          if (out_res.served_core !== oldest_result.served_core)
            report_field("served_core", oldest_result.served_core, out_res.served_core);
          if (out_res.was_write !== oldest_result.was_write)
            report_field("was_write", oldest_result.was_write, out_res.was_write);
          if (out_res.line_address !== oldest_result.line_address)
            report_field("line_address", oldest_result.line_address, out_res.line_address);
          if (out_res.line_data !== oldest_result.line_data)
            report_field("line_data", oldest_result.line_data, out_res.line_data);
          if (out_res.line_state !== oldest_result.line_state)
            report_field("line_state", oldest_result.line_state, out_res.line_state);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge.
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    mismatches  = 0;
    reads_sent  = 0;
    writes_sent = 0;
    for (int k = 0; k < 4; k++) state_seen[k] = 0;
    for (int k = 0; k < NUM_LINES; k++) begin
      shadow_tag[k]   = '0;
      shadow_value[k] = '0;
      shadow_mesi[k]  = MESI_INVALID;
    end
    for (int k = 0; k < MEMORY_WORDS; k++) shadow_mem[k] = '0;

    // Hold reset, then release it at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners, back to back.
    for (int k = 0; k < DIR_ROWS; k++)
      send_access(directed_tbl[k].req, directed_tbl[k].pinned, directed_tbl[k].res);
    drain_results();

    // Random phases; hold off between them until the block has gone quiet.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      run_random(PHASE_ITEMS);
      drain_results();
    end

    // Let any stray strobe show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d accesses (%0d reads, %0d writes), %0d from the directed table",
             reads_sent + writes_sent, reads_sent, writes_sent, DIR_ROWS);
    $display("Result states: invalid %0d, shared %0d, exclusive %0d, modified %0d",
             state_seen[MESI_INVALID], state_seen[MESI_SHARED],
             state_seen[MESI_EXCLUSIVE], state_seen[MESI_MODIFIED]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mmdc_pkg.sv
hw/rtl/mmdc_ctrl.sv
hw/rtl/mmdc_dp.sv
hw/rtl/mesi_multicore_direct_mapped_cache.sv
dv/tb.sv
